// ----- design/elgamal_modular_cipher_top_assert.svh -----
// assertion macros for the elgamal engine checker
`ifndef ELGAMAL_MODULAR_CIPHER_TOP_ASSERT_SVH
`define ELGAMAL_MODULAR_CIPHER_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define EMC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define EMC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/emc_pkg.sv -----
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types and constants of the modular elgamal engine.
// ----------------------------------------------------------------------------
package emc_pkg;
  localparam int FIELD_W       = 63;
  localparam int MOD_WIDTH_DEF = 63;

  localparam logic [1:0] MODE_ENC    = 2'd0;
  localparam logic [1:0] MODE_DEC    = 2'd1;
  localparam logic [1:0] MODE_KEY    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_GEN     = 2'd1;
  localparam logic [1:0] REG_PUB     = 2'd2;
  localparam logic [1:0] REG_PRIV    = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] plain_value;
    logic [FIELD_W-1:0] nonce;
    logic [FIELD_W-1:0] cipher_first;
    logic [FIELD_W-1:0] cipher_second;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] first_value;
    logic [FIELD_W-1:0] second_value;
  } out_item_t;

  // start request to the modular multiply unit and to the divider
  typedef struct packed {
    logic start;
  } mm_ctl_t;
endpackage

// ----- design/elgamal_modular_cipher_top.sv -----
// ----------------------------------------------------------------------------
// elgamal_modular_cipher_top
// Modular elgamal engine: encrypt, decrypt, derive public key.
// ----------------------------------------------------------------------------
// One item at a time. All products and reductions run through one bit-serial
// modular multiplier (one multiplier bit a cycle) and one restoring divider
// that takes a 63-bit dividend one quotient bit a cycle. Square-and-multiply
// scans the 63-bit exponent from its low bit; encrypt does two
// exponentiations, decrypt adds the extended euclidean loop (one division
// and one product per step). in_stall is high from acceptance until the
// result has been transferred out. No clearing pass.
module elgamal_modular_cipher_top #(
  parameter int MOD_WIDTH = emc_pkg::MOD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  emc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output emc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [emc_pkg::FIELD_W-1:0]   cfg_wdata
);
  import emc_pkg::*;
  localparam int W = MOD_WIDTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;  // reduce an operand mod p
  localparam logic [3:0] S_PSTEP = 4'd2;  // exponent bit decision
  localparam logic [3:0] S_PMUL  = 4'd3;  // acc*base
  localparam logic [3:0] S_PSQR  = 4'd4;  // base*base
  localparam logic [3:0] S_NEXT  = 4'd5;  // sequence next phase
  localparam logic [3:0] S_EDIV  = 4'd6;  // euclid divide
  localparam logic [3:0] S_EMUL  = 4'd7;  // q*x0
  localparam logic [3:0] S_FMUL  = 4'd8;  // final product
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_ESTEP = 4'd10;

  logic [FIELD_W-1:0] mod_r, gen_r, pub_r, priv_r;
  logic [3:0]  st_r, st_nxt;
  logic [2:0]  ph_r, ph_nxt;    // phase within the item
  logic [3:0]  ret_r, ret_nxt;  // state after a reduction
  logic [1:0]  mode_r, mode_nxt;
  logic [W-1:0] p_r, p_nxt, acc_r, acc_nxt, base_r, base_nxt;
  logic [FIELD_W-1:0] exp_r, exp_nxt;
  logic [W-1:0] t1_r, t1_nxt, t2_r, t2_nxt;  // saved values between phases
  logic [FIELD_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt;
  logic [W-1:0] ea_r, ea_nxt, em_r, em_nxt, x0_r, x0_nxt, x1_r, x1_nxt;
  logic [W-1:0] eq_r, eq_nxt;
  out_item_t   res_r, res_nxt;
  logic        ovld_r, ovld_nxt;

  mm_ctl_t mm_ctl, dv_ctl;
  logic [W-1:0] mm_a, mm_b, mm_prod, dv_den, dv_rem;
  logic [FIELD_W-1:0] dv_num, dv_quo;
  logic mm_done, dv_done;
  logic [FIELD_W-1:0] red_src;
  logic [W:0] x_sum;

  emc_mulmod #(.W(W)) u_mul (
    .clk, .rst_n, .ctl(mm_ctl), .a(mm_a), .b(mm_b), .p(p_r),
    .done(mm_done), .prod(mm_prod)
  );

  emc_redmod #(.W(W), .NW(FIELD_W)) u_div (
    .clk, .rst_n, .ctl(dv_ctl), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo), .rem(dv_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= FIELD_W'(3); gen_r <= FIELD_W'(2);
      pub_r <= FIELD_W'(1); priv_r <= FIELD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS: mod_r  <= cfg_wdata;
        REG_GEN:     gen_r  <= cfg_wdata;
        REG_PUB:     pub_r  <= cfg_wdata;
        REG_PRIV:    priv_r <= cfg_wdata;
        default:     mod_r  <= mod_r;
      endcase
    end
  end

  // full field-width operand, reduced mod p by the divider
  assign red_src = ra_r;

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; ret_nxt = ret_r; mode_nxt = mode_r;
    p_nxt = p_r; acc_nxt = acc_r; base_nxt = base_r; exp_nxt = exp_r;
    t1_nxt = t1_r; t2_nxt = t2_r; ra_nxt = ra_r; rb_nxt = rb_r; rc_nxt = rc_r;
    ea_nxt = ea_r; em_nxt = em_r; x0_nxt = x0_r; x1_nxt = x1_r; eq_nxt = eq_r;
    res_nxt = res_r; ovld_nxt = ovld_r;
    mm_ctl = '0; dv_ctl = '0;
    mm_a = acc_r; mm_b = base_r;
    dv_num = red_src; dv_den = p_r;
    x_sum = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_data.mode;
          p_nxt = W'(mod_r);
          ph_nxt = 3'd0;
          res_nxt = '0;
          if (W'(mod_r) < W'(2) || in_data.mode == MODE_UNUSED) begin
            st_nxt = S_OUT; ovld_nxt = 1'b1;
          end else begin
            case (in_data.mode)
              MODE_ENC: begin
                ra_nxt = gen_r; exp_nxt = in_data.nonce;
                rb_nxt = in_data.plain_value; rc_nxt = in_data.nonce;
              end
              MODE_DEC: begin
                ra_nxt = in_data.cipher_first; exp_nxt = priv_r;
                rb_nxt = in_data.cipher_second;
              end
              default: begin
                ra_nxt = gen_r; exp_nxt = priv_r;
              end
            endcase
            st_nxt = S_RED; ret_nxt = S_PSTEP; dv_ctl.start = 1'b0;
          end
        end
      end
      S_RED: begin
        // first cycle launches, waits for quotient/remainder
        if (ph_r[0] == 1'b0 && !dv_done) begin
          ph_nxt[0] = 1'b1;
          dv_num = red_src;
          dv_ctl.start = 1'b1;
        end else if (dv_done) begin
          ph_nxt[0] = 1'b0;
          base_nxt = dv_rem; acc_nxt = W'(1);
          st_nxt = ret_r;
        end
      end
      S_PSTEP: begin
        if (exp_r == '0) begin
          st_nxt = S_NEXT;
        end else if (exp_r[0]) begin
          mm_a = acc_r; mm_b = base_r; mm_ctl.start = 1'b1; st_nxt = S_PMUL;
        end else begin
          mm_a = base_r; mm_b = base_r; mm_ctl.start = 1'b1; st_nxt = S_PSQR;
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          acc_nxt = mm_prod;
          mm_a = base_r; mm_b = base_r; mm_ctl.start = 1'b1; st_nxt = S_PSQR;
        end
      end
      S_PSQR: begin
        if (mm_done) begin
          base_nxt = mm_prod; exp_nxt = exp_r >> 1; st_nxt = S_PSTEP;
        end
      end
      S_NEXT: begin
        case (mode_r)
          MODE_ENC: begin
            case (ph_r[2:1])
              2'd0: begin
                t1_nxt = acc_r; ra_nxt = pub_r; exp_nxt = rc_r;
                ph_nxt = 3'b010; st_nxt = S_RED; ret_nxt = S_PSTEP;
              end
              2'd1: begin
                t2_nxt = acc_r; ra_nxt = rb_r;
                ph_nxt = 3'b100; st_nxt = S_RED; ret_nxt = S_NEXT;
              end
              default: begin
                // base holds m mod p
                mm_a = base_r; mm_b = t2_r; mm_ctl.start = 1'b1;
                st_nxt = S_FMUL;
              end
            endcase
          end
          MODE_DEC: begin
            case (ph_r[2:1])
              2'd0: begin
                // s in acc; set up euclid
                ea_nxt = acc_r; em_nxt = p_r; x0_nxt = '0; x1_nxt = W'(1);
                ph_nxt = 3'b010; st_nxt = S_ESTEP;
              end
              2'd1: begin
                t1_nxt = x1_r; ra_nxt = rb_r;
                ph_nxt = 3'b100; st_nxt = S_RED; ret_nxt = S_NEXT;
              end
              default: begin
                mm_a = base_r; mm_b = t1_r; mm_ctl.start = 1'b1;
                st_nxt = S_FMUL;
              end
            endcase
          end
          default: begin
            res_nxt.first_value = FIELD_W'(acc_r);
            ovld_nxt = 1'b1; st_nxt = S_OUT;
          end
        endcase
      end
      S_ESTEP: begin
        if (ea_r <= W'(1)) begin
          // x1 below p except the initial 1, which p >= 2 keeps
          st_nxt = S_NEXT;
        end else if (em_r == '0) begin
          x1_nxt = '0; st_nxt = S_NEXT;
        end else begin
          dv_num = FIELD_W'(ea_r); dv_den = em_r; dv_ctl.start = 1'b1; st_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        dv_num = FIELD_W'(ea_r); dv_den = em_r;
        if (dv_done) begin
          eq_nxt = W'(dv_quo);
          ea_nxt = em_r; em_nxt = dv_rem;
          // q stays below p: the dividend never exceeds p and the divisor is
          // at least two whenever the dividend is p
          mm_a = x0_r; mm_b = W'(dv_quo);
          mm_ctl.start = 1'b1; st_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        mm_a = x0_r; mm_b = eq_r;
        if (mm_done) begin
          x_sum = {1'b0, x1_r} + {1'b0, p_r} - {1'b0, mm_prod};
          x0_nxt = (x_sum >= {1'b0, p_r}) ? W'(x_sum - {1'b0, p_r}) : W'(x_sum);
          x1_nxt = x0_r;
          st_nxt = S_ESTEP;
        end
      end
      S_FMUL: begin
        if (mm_done) begin
          if (mode_r == MODE_ENC) begin
            res_nxt.first_value = FIELD_W'(t1_r);
            res_nxt.second_value = FIELD_W'(mm_prod);
          end else begin
            res_nxt.first_value = FIELD_W'(mm_prod);
          end
          ovld_nxt = 1'b1; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          ovld_nxt = 1'b0; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovld_r <= 1'b0; ph_r <= '0;
    end else begin
      st_r <= st_nxt; ovld_r <= ovld_nxt; ph_r <= ph_nxt;
    end
    ret_r <= ret_nxt; mode_r <= mode_nxt; p_r <= p_nxt; acc_r <= acc_nxt;
    base_r <= base_nxt; exp_r <= exp_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt; rc_r <= rc_nxt; ea_r <= ea_nxt;
    em_r <= em_nxt; x0_r <= x0_nxt; x1_r <= x1_nxt; eq_r <= eq_nxt;
    res_r <= res_nxt;
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ovld_r;
  assign out_data  = res_r;
endmodule

// ----- design/emc_mulmod.sv -----
// ----------------------------------------------------------------------------
// emc_mulmod
// Bit-serial double-and-add modular multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module emc_mulmod #(
  parameter int W = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  emc_pkg::mm_ctl_t   ctl,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  input  logic [W-1:0]       p,
  output logic               done,
  output logic [W-1:0]       prod
);
  import emc_pkg::*;

  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]   sum_acc, sum_dbl;

  // operands are already below p
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sum_acc = {1'b0, acc_r} + {1'b0, a_r};
    sum_dbl = {1'b0, a_r} + {1'b0, a_r};
    if (ctl.start) begin
      a_nxt = a; b_nxt = b; acc_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        if (b_r[0]) begin
          acc_nxt = (sum_acc >= {1'b0, p}) ? W'(sum_acc - {1'b0, p}) : W'(sum_acc);
        end
        a_nxt = (sum_dbl >= {1'b0, p}) ? W'(sum_dbl - {1'b0, p}) : W'(sum_dbl);
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ----- design/emc_redmod.sv -----
// ----------------------------------------------------------------------------
// emc_redmod
// Restoring divider: quotient and remainder, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module emc_redmod #(
  parameter int W  = 63,
  parameter int NW = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  emc_pkg::mm_ctl_t   ctl,
  input  logic [NW-1:0]      num,
  input  logic [W-1:0]       den,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic [W-1:0]       rem
);
  import emc_pkg::*;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    r_r, r_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r[W-1:0], q_r[NW-1]};
    if (ctl.start) begin
      q_nxt = num; d_nxt = den; r_nxt = '0; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = W'(r_r);
endmodule

// ----- design/emc_checker.sv -----
// ----------------------------------------------------------------------------
// emc_checker
// Port-level checks of the elgamal engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "elgamal_modular_cipher_top_assert.svh"

module emc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input emc_pkg::out_item_t   out_data
);
  import emc_pkg::*;

  // one item in flight: nothing accepted while a result waits
  `EMC_ASSERT_IMP(a_no_accept_busy, out_valid, in_stall)
  // a transfer in makes the block busy
  `EMC_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall)
  // stalled result holds
  `EMC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // after an output transfer the block is idle
  `EMC_ASSERT_NXT(a_idle_after_out, out_valid && !out_stall, !out_valid && !in_stall)
endmodule

bind elgamal_modular_cipher_top emc_checker u_emc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

// ----- verif/emc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// emc_scoreboard
// Watches the item, result and register ports of the elgamal engine, works
// out the expected result of every accepted item and compares each result
// transfer against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module emc_scoreboard (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  emc_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  emc_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [emc_pkg::FIELD_W-1:0]  cfg_wdata,
  output int                           fail_count,
  output int                           pending
);
  import emc_pkg::*;

  logic [63:0] mod_r, gen_r, pub_r, priv_r;
  out_item_t   cipher_q[$];

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [127:0] prod;
    prod = {64'd0, a % p} * {64'd0, b % p};
    return 64'(prod % {64'd0, p});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] p);
    logic [63:0] acc;
    logic [63:0] b;
    acc = 1;
    b = base % p;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, p);
      b = mulmod(b, b, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  // euclid with coefficients held mod p; shared factor yields 0
  function automatic logic [63:0] invmod(logic [63:0] a, logic [63:0] p);
    logic [63:0] m, x0, x1, q, t;
    m = p;
    x0 = 0;
    x1 = 1;
    while (a > 1) begin
      if (m == 0) return 0;
      q = a / m;
      t = m;
      m = a % m;
      a = t;
      t = x0;
      x0 = x1 + p - mulmod(q, x0, p);
      if (x0 >= p) x0 = x0 - p;
      x1 = t;
    end
    return x1 % p;
  endfunction

  function automatic out_item_t predict_cipher(in_item_t it);
    out_item_t   r;
    logic [63:0] p, s;
    r = '0;
    p = mod_r;
    if (p >= 2) begin
      case (it.mode)
        MODE_ENC: begin
          r.first_value  = FIELD_W'(powmod(gen_r, {1'b0, it.nonce}, p));
          r.second_value = FIELD_W'(mulmod({1'b0, it.plain_value},
                                           powmod(pub_r, {1'b0, it.nonce}, p), p));
        end
        MODE_DEC: begin
          s = powmod({1'b0, it.cipher_first}, priv_r, p);
          r.first_value = FIELD_W'(mulmod({1'b0, it.cipher_second}, invmod(s, p), p));
        end
        MODE_KEY: r.first_value = FIELD_W'(powmod(gen_r, priv_r, p));
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      mod_r  <= 64'd3;
      gen_r  <= 64'd2;
      pub_r  <= 64'd1;
      priv_r <= 64'd1;
      fail_count <= 0;
      cipher_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS: mod_r  <= {1'b0, cfg_wdata};
          REG_GEN:     gen_r  <= {1'b0, cfg_wdata};
          REG_PUB:     pub_r  <= {1'b0, cfg_wdata};
          REG_PRIV:    priv_r <= {1'b0, cfg_wdata};
          default: ;
        endcase
      end
      if (in_valid && !in_stall) cipher_q = {cipher_q, predict_cipher(in_data)};
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected result transfer, got %h/%h", $time,
                   out_data.first_value, out_data.second_value);
          errs++;
        end else begin
          want = cipher_q.pop_front();
          if (out_data.first_value !== want.first_value) begin
            $display("%0t: first_value expected %h got %h", $time,
                     want.first_value, out_data.first_value);
            errs++;
          end
          if (out_data.second_value !== want.second_value) begin
            $display("%0t: second_value expected %h got %h", $time,
                     want.second_value, out_data.second_value);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives encrypt, decrypt, key-derive and unused-mode items through the
// elgamal engine under several moduli and keys, with random idle cycles on
// both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import emc_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_wdata;
  int fail_count;
  int pending;

  bit quiet;        // no idle cycles on either side
  bit long_hold;    // receiver holds off for a long stretch
  int idle_cycles = 0;
  int mode_cnt[4];

  elgamal_modular_cipher_top dut (.*);

  emc_scoreboard u_checker (.*);

  initial begin
    clk = 0;
    forever begin
      #1 clk = 1;
      #1 clk = 0;
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver side
  initial begin
    int w;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        w = quiet ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic [62:0] rnd63();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return 63'($urandom_range(0, 20));
      1: return MAX63 - 63'($urandom_range(0, 3));
      default: return v[62:0];
    endcase
  endfunction

  task automatic send(logic [1:0] mode, logic [62:0] m, logic [62:0] r,
                      logic [62:0] c1, logic [62:0] c2);
    int gap;
    in_data <= '{mode: mode, plain_value: m, nonce: r, cipher_first: c1, cipher_second: c2};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    mode_cnt[mode]++;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_put(logic [1:0] idx, logic [62:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_keys(logic [62:0] p, logic [62:0] g, logic [62:0] e2, logic [62:0] d);
    cfg_put(REG_MODULUS, p);
    cfg_put(REG_GEN, g);
    cfg_put(REG_PUB, e2);
    cfg_put(REG_PRIV, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [1:0] rnd_mode();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return MODE_UNUSED;
    if (k < 8) return MODE_ENC;
    if (k < 16) return MODE_DEC;
    return MODE_KEY;
  endfunction

  logic [62:0] primes[5];

  initial begin
    primes = '{63'd251, 63'd1000003, 63'd4294967291, 63'h1FFF_FFFF_FFFF_FFFF,
               63'd9223372036854775783};
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODULUS;
    cfg_wdata <= '0;
    quiet = 0;
    long_hold = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys, every mode
    send(MODE_ENC, MAX63, MAX63, 0, 0);
    send(MODE_DEC, 0, 0, MAX63, MAX63);
    send(MODE_KEY, 0, 0, 0, 0);
    send(MODE_UNUSED, MAX63, MAX63, MAX63, MAX63);
    drain();

    // large prime, zero exponent, zero and multiple-of-p bases
    set_keys(63'h1FFF_FFFF_FFFF_FFFF, 63'd37, 63'd123456789, MAX63);
    send(MODE_ENC, MAX63, 0, 0, 0);
    send(MODE_ENC, 63'd5, MAX63, 0, 0);
    send(MODE_DEC, 0, 0, 0, MAX63);
    send(MODE_DEC, 0, 0, 63'h1FFF_FFFF_FFFF_FFFF, 63'd77);
    send(MODE_DEC, 0, 0, 63'd2, 63'd1000);
    send(MODE_KEY, 0, 0, 0, 0);
    drain();

    // composite modulus: shared factor has no inverse
    set_keys(63'd15, 63'd4, 63'd7, 63'd3);
    send(MODE_DEC, 0, 0, 63'd3, 63'd11);
    send(MODE_DEC, 0, 0, 63'd2, 63'd11);
    send(MODE_ENC, 63'd14, 63'd9, 0, 0);
    drain();

    // modulus below two
    set_keys(63'd0, 63'd2, 63'd3, 63'd5);
    send(MODE_ENC, 63'd1, 63'd1, 0, 0);
    send(MODE_DEC, 0, 0, 63'd1, 63'd1);
    drain();
    set_keys(63'd1, 63'd2, 63'd3, 63'd5);
    send(MODE_KEY, 0, 0, 0, 0);
    drain();

    // top of range, zero private key and public key
    set_keys(MAX63, MAX63, 63'd0, 63'd0);
    send(MODE_ENC, MAX63, MAX63, 0, 0);
    send(MODE_DEC, 0, 0, MAX63, MAX63);
    send(MODE_KEY, 0, 0, 0, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      set_keys(ph == 4 ? rnd63() : primes[$urandom_range(0, 4)],
               rnd63(), rnd63(), rnd63());
      quiet = (ph == 1);
      for (int i = 0; i < 20; i++) begin
        if (ph == 2 && i == 3) long_hold = 1;
        send(rnd_mode(), rnd63(), rnd63(), rnd63(), rnd63());
      end
      quiet = 0;
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d encrypt, %0d decrypt, %0d key-derive, %0d unused-mode items",
             mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
    $display("over reset keys, prime and composite moduli, moduli below two, range tops");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
